>>> sv/slgd_pkg.sv
// Shared types, register indexes and reset values for the structured-light
// Gray code decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slgd_pkg;

    localparam int PIXEL_COUNT_DEF = 524288;
    localparam int MAX_BITS_DEF    = 12;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COLUMN_BIT_COUNT = 3'd0,
        CFG_ROW_BIT_COUNT    = 3'd1,
        CFG_COLUMN_PHASE     = 3'd2,
        CFG_ROW_PHASE        = 3'd3,
        CFG_COLUMN_LIMIT     = 3'd4,
        CFG_ROW_LIMIT        = 3'd5
    } cfg_index_t;

    localparam logic [3:0]  RST_BIT_COUNT = 4'd10;
    localparam logic [10:0] RST_PHASE     = 11'd112;
    localparam logic [12:0] RST_LIMIT     = 13'd800;

    typedef struct packed {
        logic [3:0]  column_bit_count;
        logic [3:0]  row_bit_count;
        logic [10:0] column_phase;
        logic [10:0] row_phase;
        logic [12:0] column_limit;
        logic [12:0] row_limit;
    } cfg_t;

    typedef struct packed {
        logic        axis;
        logic [3:0]  plane;
        logic [18:0] pixel_index;
        logic [7:0]  gray_sample;
        logic [7:0]  inverse_sample;
    } pixel_item_t;

    typedef struct packed {
        logic        out_axis;
        logic [18:0] out_pixel;
        logic [12:0] coordinate;
        logic        clamped;
    } coord_item_t;

endpackage

`default_nettype wire

>>> sv/slgd_cfg.sv
// Configuration register bank of the Gray code decoder.
// Depends on slgd_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module slgd_cfg
    import slgd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            // Writes to indexes beyond the bank are dropped.
            unique case (cfg_index)
                CFG_COLUMN_BIT_COUNT: cfg_next.column_bit_count = cfg_data[3:0];
                CFG_ROW_BIT_COUNT:    cfg_next.row_bit_count    = cfg_data[3:0];
                CFG_COLUMN_PHASE:     cfg_next.column_phase     = cfg_data[10:0];
                CFG_ROW_PHASE:        cfg_next.row_phase        = cfg_data[10:0];
                CFG_COLUMN_LIMIT:     cfg_next.column_limit     = cfg_data;
                CFG_ROW_LIMIT:        cfg_next.row_limit        = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.column_bit_count <= RST_BIT_COUNT;
            cfg_reg.row_bit_count    <= RST_BIT_COUNT;
            cfg_reg.column_phase     <= RST_PHASE;
            cfg_reg.row_phase        <= RST_PHASE;
            cfg_reg.column_limit     <= RST_LIMIT;
            cfg_reg.row_limit        <= RST_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> sv/slgd_pixel_ram.sv
// Per-pixel state store: one write port and one read port, registered read.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module slgd_pixel_ram #(
    parameter int DEPTH  = 524288,
    parameter int ADDR_W = 19,
    parameter int DATA_W = 13
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A read and a write of the same entry at one edge returns the old contents.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> sv/structured_light_gray_decoder.sv
// Top level of the structured-light Gray code decoder: input checks, the
// read-modify-write stage on the pixel store and the result register.
// Depends on slgd_pkg, slgd_cfg and slgd_pixel_ram.
//
//  Channel  Signals                               Payload
//  -------  ------------------------------------  ----------------------
//  pixel    pixel_valid, pixel_ready, pixel       pixel_item_t
//  coord    coord_valid, coord_ready, coord       coord_item_t
//  cfg      cfg_write, cfg_index, cfg_data        write only, no wait
//
// One pixel transfer is taken every clock; a result is presented from the output
// register after the transfer of its last plane. The rate is set by the single
// read port and single write port of the pixel store, with a one-entry forward
// covering a read that meets the write of the same pixel. Reset clears control
// state only; the store holds no valid bits and needs no clearing pass. The input
// stalls only while a result is held in the output register and not taken.
`timescale 1ns / 1ps
`default_nettype none

module structured_light_gray_decoder
    import slgd_pkg::*;
#(
    parameter int PIXEL_COUNT = PIXEL_COUNT_DEF,
    parameter int MAX_BITS    = MAX_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   pixel_valid,
    output logic                        pixel_ready,
    input  wire pixel_item_t            pixel,
    output logic                        coord_valid,
    input  wire logic                   coord_ready,
    output coord_item_t                 coord,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int ADDR_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int DATA_W = MAX_BITS + 1;
    localparam int VAL_W  = ((MAX_BITS > 13) ? MAX_BITS : 13) + 1;

    typedef struct packed {
        logic                axis;
        logic [18:0]         pixel_index;
        logic [ADDR_W-1:0]   addr;
        logic                bit_value;
        logic                first;
        logic                last;
        logic [MAX_BITS-1:0] weight;
    } stage_t;

    cfg_t cfg;

    slgd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // ---------------- Input checks ----------------
    logic [4:0]          count_raw;
    logic [4:0]          count_sat;
    logic [4:0]          plane_ext;
    logic                in_range;
    logic                accept;
    logic                take;
    stage_t              entry;

    always_comb
    begin
        count_raw = {1'b0, (pixel.axis ? cfg.row_bit_count : cfg.column_bit_count)};
        count_sat = (32'(count_raw) > MAX_BITS) ? 5'(MAX_BITS) : count_raw;
        plane_ext = {1'b0, pixel.plane};
        in_range  = (plane_ext < count_sat) && (32'(pixel.pixel_index) < PIXEL_COUNT);
        entry.axis        = pixel.axis;
        entry.pixel_index = pixel.pixel_index;
        entry.addr        = ADDR_W'(pixel.pixel_index);
        entry.bit_value   = (pixel.gray_sample >= pixel.inverse_sample);
        entry.first       = (pixel.plane == 4'd0);
        entry.last        = (plane_ext == (count_sat - 5'd1));
        entry.weight      = MAX_BITS'(1) << (count_sat - plane_ext - 5'd1);
    end

    // ---------------- Read-modify-write stage ----------------
    logic                s1_valid_reg;
    logic                s1_valid_next;
    stage_t              s1_reg;
    logic [DATA_W-1:0]   rd_data;
    logic                fwd_valid_reg;
    logic                fwd_valid_next;
    logic [ADDR_W-1:0]   fwd_addr_reg;
    logic [DATA_W-1:0]   fwd_data_reg;
    logic [DATA_W-1:0]   old_state;
    logic                run;
    logic [MAX_BITS-1:0] code;
    logic                advance;
    logic                wr_en;
    logic [VAL_W-1:0]    diff;
    logic [VAL_W-1:0]    limit_ext;
    logic                out_of_range;

    logic                coord_valid_reg;
    logic                coord_valid_next;
    coord_item_t         coord_reg;

    assign advance     = !(s1_valid_reg && s1_reg.last && coord_valid_reg && !coord_ready);
    assign pixel_ready = advance;
    assign accept      = pixel_valid && advance;
    assign take        = accept && in_range;

    slgd_pixel_ram #(
        .DEPTH  (PIXEL_COUNT),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_reg.addr),
        .wr_data ({run, code}),
        .rd_en   (take),
        .rd_addr (entry.addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        // The store read at the edge of the previous write misses it; take it here.
        old_state = (fwd_valid_reg && (fwd_addr_reg == s1_reg.addr)) ? fwd_data_reg : rd_data;
        if (s1_reg.first)
        begin
            run  = s1_reg.bit_value;
            code = '0;
        end
        else
        begin
            run  = old_state[MAX_BITS] ^ s1_reg.bit_value;
            code = old_state[MAX_BITS-1:0];
        end
        if (run)
        begin
            code = code | s1_reg.weight;
        end
        wr_en = s1_valid_reg && advance;

        limit_ext    = VAL_W'(s1_reg.axis ? cfg.row_limit : cfg.column_limit);
        diff         = VAL_W'(code) - VAL_W'(s1_reg.axis ? cfg.row_phase : cfg.column_phase);
        out_of_range = diff[VAL_W-1] || (diff > limit_ext);

        s1_valid_next  = advance ? take : s1_valid_reg;
        fwd_valid_next = advance ? wr_en : fwd_valid_reg;

        if (advance && s1_valid_reg && s1_reg.last)
        begin
            coord_valid_next = 1'b1;
        end
        else if (coord_ready)
        begin
            coord_valid_next = 1'b0;
        end
        else
        begin
            coord_valid_next = coord_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            coord_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            fwd_valid_reg   <= fwd_valid_next;
            coord_valid_reg <= coord_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_reg <= entry;
        end
        if (wr_en)
        begin
            fwd_addr_reg <= s1_reg.addr;
            fwd_data_reg <= {run, code};
        end
        if (advance && s1_valid_reg && s1_reg.last)
        begin
            coord_reg.out_axis   <= s1_reg.axis;
            coord_reg.out_pixel  <= s1_reg.pixel_index;
            coord_reg.coordinate <= out_of_range ? 13'd0 : diff[12:0];
            coord_reg.clamped    <= out_of_range;
        end
    end

    assign coord_valid = coord_valid_reg;
    assign coord       = coord_reg;

endmodule

`default_nettype wire
